@@ rtl/core/carf_pkg.sv @@
`default_nettype none
package carf_pkg;

    localparam int REGION_COUNT = 16;
    localparam int IDX_W        = (REGION_COUNT > 1) ? $clog2(REGION_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REGION_COUNT - 1);

    localparam int ADDR_W   = 64;
    localparam int DEV_W    = 5;
    localparam int FLAGS_W  = 6;
    localparam int MASK_W   = 32;
    localparam int KIND_W   = 3;
    localparam int ENTRY_W  = 4;
    localparam int LINE_LSB = 6;
    localparam int EXCL_BIT = 2;

    localparam logic [KIND_W-1:0] KIND_READ_EXCL = 3'd1;
    localparam logic [KIND_W-1:0] KIND_WRITEBACK = 3'd2;
    localparam logic [KIND_W-1:0] KIND_REVOKE    = 3'd5;

    localparam logic [1:0] ST_I = 2'd0;
    localparam logic [1:0] ST_E = 2'd2;
    localparam logic [1:0] ST_M = 2'd3;

    typedef struct packed {
        logic               mode;
        logic [ENTRY_W-1:0] entry_index;
        logic [KIND_W-1:0]  txn_kind;
        logic [ADDR_W-1:0]  address;
        logic [DEV_W-1:0]   requester_id;
        logic [FLAGS_W-1:0] access_flags;
        logic [ADDR_W-1:0]  region_start_in;
        logic [ADDR_W-1:0]  region_end_in;
        logic [FLAGS_W-1:0] region_flags_in;
        logic [MASK_W-1:0]  device_mask_in;
        logic               exclusive_ok_in;
    } t_req;

    typedef struct packed {
        logic               allowed;
        logic [ADDR_W-1:0]  line_address;
        logic [1:0]         prior_state;
        logic [1:0]         next_state;
        logic [FLAGS_W-1:0] matched_flags;
    } t_res;

    typedef struct packed {
        logic               exclusive_ok;
        logic [MASK_W-1:0]  devices;
        logic [FLAGS_W-1:0] flags;
        logic [ADDR_W-1:0]  limit_addr;
        logic [ADDR_W-1:0]  base_addr;
    } t_entry;

    function automatic logic [1:0] prior_of(input logic [KIND_W-1:0] kind);
        logic [1:0] st;
        st = ST_I;
        if (kind == KIND_REVOKE) begin
            st = ST_E;
        end else if (kind == KIND_WRITEBACK) begin
            st = ST_M;
        end
        return st;
    endfunction

    function automatic logic [1:0] next_of(input logic [KIND_W-1:0] kind);
        return (kind == KIND_READ_EXCL) ? ST_E : ST_I;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/carf_ram.sv @@
`default_nettype none
module carf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_wr_addr,
    input  wire logic [WIDTH-1:0]                              i_wr_data,
    input  wire logic                                          i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_rd_addr,
    output logic      [WIDTH-1:0]                              o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/carf_ctrl.sv @@
`default_nettype none
module carf_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_req_valid,
    output logic               o_req_ready,
    input  wire carf_pkg::t_req i_req,
    output logic               o_res_valid,
    output carf_pkg::t_res     o_res,
    input  wire logic          i_res_take
);
    import carf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state              r_state, n_state;
    t_res                r_res, n_res;
    logic [REGION_COUNT-1:0] r_valid;
    logic [IDX_W-1:0]    r_rd_idx, r_cmp_idx;
    logic                r_rd_done, r_cmp_live;
    logic [ADDR_W-1:0]   r_line;
    logic [DEV_W-1:0]    r_dev;
    logic                r_excl;
    logic [KIND_W-1:0]   r_kind;

    logic                accept, screen, wr_en, rd_en, present, deny;
    logic [ADDR_W-1:0]   line;
    logic [IDX_W-1:0]    wr_addr;
    logic [$bits(t_entry)-1:0] rd_data;
    t_entry              ent, wr_ent;

    assign accept  = i_req_valid && (r_state == S_IDLE);
    assign line    = {i_req.address[ADDR_W-1:LINE_LSB], LINE_LSB'(0)};
    assign screen  = (i_req.txn_kind == KIND_READ_EXCL) || i_req.access_flags[EXCL_BIT];
    assign wr_en   = accept && i_req.mode && (32'(i_req.entry_index) < REGION_COUNT);
    assign wr_addr = IDX_W'(i_req.entry_index);
    assign rd_en   = (r_state == S_SCAN) && !r_rd_done;

    always_comb begin
        wr_ent.base_addr    = i_req.region_start_in;
        wr_ent.limit_addr   = i_req.region_end_in;
        wr_ent.flags        = i_req.region_flags_in;
        wr_ent.devices      = i_req.device_mask_in;
        wr_ent.exclusive_ok = i_req.exclusive_ok_in;
    end

    carf_ram #(
        .WIDTH($bits(t_entry)),
        .DEPTH(REGION_COUNT)
    ) u_table (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_ent),
        .i_rd_en  (rd_en),
        .i_rd_addr(r_rd_idx),
        .o_rd_data(rd_data)
    );

    assign ent     = t_entry'(rd_data);
    assign present = r_valid[r_cmp_idx] && (ent.base_addr != '0)
                     && (r_line >= ent.base_addr) && (r_line < ent.limit_addr);
    assign deny    = ((ent.devices != '0) && !ent.devices[r_dev])
                     || (r_excl && !ent.exclusive_ok);

    always_comb begin
        n_state = r_state;
        n_res   = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.mode) begin
                        n_res         = '0;
                        n_res.allowed = 1'b1;
                        n_state       = S_DONE;
                    end else if (screen) begin
                        n_state = S_SCAN;
                    end else begin
                        n_res.allowed       = 1'b1;
                        n_res.line_address  = line;
                        n_res.prior_state   = prior_of(i_req.txn_kind);
                        n_res.next_state    = next_of(i_req.txn_kind);
                        n_res.matched_flags = '0;
                        n_state             = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (r_cmp_live && (present || (r_cmp_idx == LAST_IDX))) begin
                    n_res.line_address = r_line;
                    if (present && deny) begin
                        n_res.allowed       = 1'b0;
                        n_res.prior_state   = ST_I;
                        n_res.next_state    = ST_I;
                        n_res.matched_flags = '0;
                    end else begin
                        n_res.allowed       = 1'b1;
                        n_res.prior_state   = prior_of(r_kind);
                        n_res.next_state    = next_of(r_kind);
                        n_res.matched_flags = present ? ent.flags : '0;
                    end
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_valid    <= '0;
            r_rd_done  <= 1'b1;
            r_cmp_live <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (r_state == S_SCAN) begin
                r_cmp_live <= !r_rd_done;
                if (r_rd_idx == LAST_IDX) begin
                    r_rd_done <= 1'b1;
                end
            end else begin
                r_cmp_live <= 1'b0;
                r_rd_done  <= !(accept && !i_req.mode && screen);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_line   <= line;
            r_dev    <= i_req.requester_id;
            r_excl   <= i_req.access_flags[EXCL_BIT];
            r_kind   <= i_req.txn_kind;
            r_rd_idx <= '0;
        end else if (rd_en) begin
            r_cmp_idx <= r_rd_idx;
            if (r_rd_idx != LAST_IDX) begin
                r_rd_idx <= r_rd_idx + 1'b1;
            end
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_write_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_req.mode) |=> (r_state == S_DONE && r_res.allowed))
        else $error("table write did not complete in one cycle");

    a_deny_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !r_res.allowed) |->
        (r_res.prior_state == ST_I && r_res.next_state == ST_I && r_res.matched_flags == '0))
        else $error("denied request carries state or flags");

    a_cmp_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_cmp_live) |-> (r_cmp_idx == $past(r_rd_idx)))
        else $error("compared entry is not the one read last cycle");

    a_hold_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && !i_res_take) |=> (r_state == S_DONE && $stable(r_res)))
        else $error("result dropped before it was taken");

endmodule
`default_nettype wire

@@ rtl/core/coherence_access_region_firewall_top.sv @@
// A table write or an unscreened check puts its result in the result register, and the output
// register then takes it and raises m_tvalid. A screened check reads one region entry per cycle
// from the table memory in index order and stops at the first matching entry or the last one.
// A new request is accepted only after the previous result has moved into the output register.
// Reset clears the entry valid bits, so every region reads as empty; no clearing pass runs.
// The output register holds a result while the next request is accepted.
`default_nettype none
module coherence_access_region_firewall_top (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // entry_index, txn_kind, address, requester_id, access_flags, region_start_in,
    // region_end_in, region_flags_in, device_mask_in, exclusive_ok_in, zero pad
    input  wire logic [255:0] s_tdata,
    // mode
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // allowed, line_address, prior_state, next_state, matched_flags, zero pad
    output logic [79:0]       m_tdata
);
    import carf_pkg::*;

    t_req  req;
    t_res  res;
    t_res  r_out;
    logic  r_out_valid;
    logic  res_valid, take;

    always_comb begin
        req.mode            = s_tuser;
        req.entry_index     = s_tdata[3:0];
        req.txn_kind        = s_tdata[6:4];
        req.address         = s_tdata[70:7];
        req.requester_id    = s_tdata[75:71];
        req.access_flags    = s_tdata[81:76];
        req.region_start_in = s_tdata[145:82];
        req.region_end_in   = s_tdata[209:146];
        req.region_flags_in = s_tdata[215:210];
        req.device_mask_in  = s_tdata[247:216];
        req.exclusive_ok_in = s_tdata[248];
    end

    carf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_tvalid),
        .o_req_ready(s_tready),
        .i_req      (req),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_take (take)
    );

    assign take = res_valid && (!r_out_valid || m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= res;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {5'd0, r_out.matched_flags, r_out.next_state, r_out.prior_state,
                       r_out.line_address, r_out.allowed};

endmodule
`default_nettype wire

@@ tb/coherence_access_region_firewall_top_tb.sv @@
`timescale 1ns / 100ps

import carf_pkg::*;

class firewall_verdict_board;
    t_entry regions[REGION_COUNT];
    t_res   verdicts[$];
    int     errors;

    function new();
        int i;
        for (i = 0; i < REGION_COUNT; i++) begin
            regions[i] = '0;
        end
        errors = 0;
    endfunction

    // Works out the verdict of one accepted request and updates the region table copy.
    function void note_request(t_req r);
        t_res       v;
        logic [63:0] line;
        logic       hit;
        logic       ok;
        logic [5:0] flags;
        int         i;
        v = '0;
        v.allowed = 1'b1;
        if (r.mode) begin
            regions[r.entry_index] = '{exclusive_ok: r.exclusive_ok_in,
                                       devices:      r.device_mask_in,
                                       flags:        r.region_flags_in,
                                       limit_addr:   r.region_end_in,
                                       base_addr:    r.region_start_in};
            verdicts.push_back(v);
            return;
        end
        line = {r.address[ADDR_W-1:LINE_LSB], {LINE_LSB{1'b0}}};
        ok = 1'b1;
        hit = 1'b0;
        flags = '0;
        if (r.txn_kind == KIND_READ_EXCL || r.access_flags[EXCL_BIT]) begin
            for (i = 0; i < REGION_COUNT; i++) begin
                if (!hit && regions[i].base_addr != 0 && line >= regions[i].base_addr
                        && line < regions[i].limit_addr) begin
                    hit = 1'b1;
                    if (regions[i].devices != 0 && !regions[i].devices[r.requester_id]) begin
                        ok = 1'b0;
                    end else if (r.access_flags[EXCL_BIT] && !regions[i].exclusive_ok) begin
                        ok = 1'b0;
                    end else begin
                        flags = regions[i].flags;
                    end
                end
            end
        end
        v.allowed = ok;
        v.line_address = line;
        v.prior_state = ST_I;
        v.next_state = ST_I;
        if (ok) begin
            v.matched_flags = flags;
            case (r.txn_kind)
                KIND_READ_EXCL: begin
                    v.next_state = ST_E;
                end
                KIND_REVOKE: begin
                    v.prior_state = ST_E;
                end
                KIND_WRITEBACK: begin
                    v.prior_state = ST_M;
                end
                default: begin
                end
            endcase
        end
        verdicts.push_back(v);
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] seen);
        if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
            errors++;
        end
    endfunction

    function void check_verdict(t_res got);
        t_res want;
        if (verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = verdicts.pop_front();
        compare_field("allowed", 64'(want.allowed), 64'(got.allowed));
        compare_field("line_address", want.line_address, got.line_address);
        compare_field("prior_state", 64'(want.prior_state), 64'(got.prior_state));
        compare_field("next_state", 64'(want.next_state), 64'(got.next_state));
        compare_field("matched_flags", 64'(want.matched_flags), 64'(got.matched_flags));
    endfunction
endclass

module coherence_access_region_firewall_top_tb;

    typedef enum logic [KIND_W-1:0] {
        K_READ_SHARED,
        K_READ_EXCL,
        K_WRITEBACK,
        K_EVICT,
        K_INVALIDATE,
        K_REVOKE,
        K_UNDEF6,
        K_UNDEF7
    } t_kind;

    localparam logic MODE_CHECK = 1'b0;
    localparam logic MODE_WRITE = 1'b1;
    localparam int   RANDOM_ITEMS = 1100;

    logic         i_clk;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;

    firewall_verdict_board board;
    int   burst_left = 0;
    int   ready_hold = 0;
    t_res got;

    coherence_access_region_firewall_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("coherence_access_region_firewall_top_tb: done, errors");
        $finish;
    end

    always @(posedge i_clk) begin
        if (ready_hold == 0) begin
            m_tready <= ($urandom_range(0, 2) != 0);
            ready_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 3);
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            got.allowed       = m_tdata[0];
            got.line_address  = m_tdata[64:1];
            got.prior_state   = m_tdata[66:65];
            got.next_state    = m_tdata[68:67];
            got.matched_flags = m_tdata[74:69];
            board.check_verdict(got);
        end
    end

    function automatic t_req noise_req();
        t_req r;
        r.mode            = 1'($urandom);
        r.entry_index     = 4'($urandom);
        r.txn_kind        = 3'($urandom);
        r.address         = {$urandom, $urandom};
        r.requester_id    = 5'($urandom);
        r.access_flags    = 6'($urandom);
        r.region_start_in = {$urandom, $urandom};
        r.region_end_in   = {$urandom, $urandom};
        r.region_flags_in = 6'($urandom);
        r.device_mask_in  = $urandom;
        r.exclusive_ok_in = 1'($urandom);
        return r;
    endfunction

    function automatic logic [31:0] hi_pick();
        logic [31:0] hi;
        case ($urandom_range(0, 3))
            0: hi = 32'h0000_0000;
            1: hi = 32'h0000_0001;
            2: hi = 32'h8000_0000;
            default: hi = 32'hFFFF_FFFF;
        endcase
        return hi;
    endfunction

    // The sender moves requests in bursts of random length separated by random gaps.
    task automatic send_request(input t_req r);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {7'b0, r.exclusive_ok_in, r.device_mask_in, r.region_flags_in,
                     r.region_end_in, r.region_start_in, r.access_flags, r.requester_id,
                     r.address, r.txn_kind, r.entry_index};
        do @(posedge i_clk); while (!s_tready);
        board.note_request(r);
    endtask

    task automatic put_region(input logic [3:0] idx, input logic [63:0] base_addr,
                              input logic [63:0] stop_addr, input logic [5:0] flags,
                              input logic [31:0] mask, input logic excl);
        t_req r;
        r = noise_req();
        r.mode            = MODE_WRITE;
        r.entry_index     = idx;
        r.region_start_in = base_addr;
        r.region_end_in   = stop_addr;
        r.region_flags_in = flags;
        r.device_mask_in  = mask;
        r.exclusive_ok_in = excl;
        send_request(r);
    endtask

    task automatic put_txn(input t_kind kind, input logic [63:0] addr,
                           input logic [4:0] dev, input logic [5:0] aflags);
        t_req r;
        r = noise_req();
        r.mode         = MODE_CHECK;
        r.txn_kind     = kind;
        r.address      = addr;
        r.requester_id = dev;
        r.access_flags = aflags;
        send_request(r);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (board.verdicts.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int          n;
        int          j;
        logic [63:0] base_addr;
        logic [63:0] stop_addr;
        logic [63:0] addr;
        logic [31:0] mask;
        logic [4:0]  dev;
        logic [5:0]  aflags;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_region(4'd0, 64'h1000, 64'h2000, 6'h15, 32'h0, 1'b1);
        put_region(4'd1, 64'h1000, 64'h3000, 6'h2A, 32'h0000_0008, 1'b0);
        put_region(4'd2, 64'h4000, 64'h5000, 6'h3F, 32'h8000_0000, 1'b1);
        put_region(4'd3, 64'h6000, 64'h6000, 6'h01, 32'h0, 1'b1);
        put_region(4'd15, 64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF, 6'h3F,
                   32'hFFFF_FFFF, 1'b0);
        put_region(4'd4, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 6'h3F, 32'h0, 1'b1);
        put_txn(K_READ_EXCL, 64'h1040, 5'd0, 6'h00);
        put_txn(K_READ_SHARED, 64'h1ABC, 5'd7, 6'h04);
        put_txn(K_READ_EXCL, 64'h2010, 5'd3, 6'h00);
        put_txn(K_READ_EXCL, 64'h2010, 5'd4, 6'h00);
        put_txn(K_WRITEBACK, 64'h2FFF, 5'd3, 6'h04);
        put_txn(K_READ_EXCL, 64'h403F, 5'd31, 6'h3F);
        put_txn(K_READ_EXCL, 64'h6000, 5'd0, 6'h00);
        put_txn(K_READ_EXCL, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 6'h00);
        put_txn(K_REVOKE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd31, 6'h04);
        put_txn(K_READ_EXCL, 64'h0, 5'd0, 6'h00);
        put_txn(K_READ_SHARED, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_WRITEBACK, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_EVICT, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_INVALIDATE, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_REVOKE, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_UNDEF6, 64'h1000, 5'd4, 6'h3B);
        put_txn(K_UNDEF7, 64'h1000, 5'd4, 6'h3B);
        put_region(4'd0, 64'h0, 64'h2000, 6'h15, 32'h0, 1'b1);
        put_txn(K_READ_EXCL, 64'h1040, 5'd4, 6'h00);
        drain_results();

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                drain_results();
            end
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 15))
                    0: begin
                        base_addr = 64'h0;
                        stop_addr = {$urandom, $urandom};
                    end
                    1, 2: begin
                        base_addr = {$urandom, $urandom};
                        stop_addr = {$urandom, $urandom};
                    end
                    default: begin
                        base_addr = {hi_pick(), 32'($urandom_range(1, 1023) * 64)};
                        if ($urandom_range(0, 3) == 0) begin
                            base_addr[5:0] = 6'($urandom);
                        end
                        stop_addr = base_addr + 64'($urandom_range(0, 4096));
                        if ($urandom_range(0, 7) == 0) begin
                            stop_addr = stop_addr - 64'd8192;
                        end
                    end
                endcase
                case ($urandom_range(0, 2))
                    0: mask = 32'h0;
                    1: mask = 32'h1 << $urandom_range(0, 31);
                    default: mask = $urandom;
                endcase
                put_region(4'($urandom), base_addr, stop_addr, 6'($urandom), mask,
                           1'($urandom));
            end else begin
                j = $urandom_range(0, REGION_COUNT - 1);
                if (board.regions[j].base_addr != 0 && $urandom_range(0, 3) != 0) begin
                    addr = board.regions[j].base_addr + 64'($urandom_range(0, 4300))
                           - 64'd128;
                end else if ($urandom_range(0, 1) == 0) begin
                    addr = {hi_pick(), 32'($urandom_range(0, 70000))};
                end else begin
                    addr = {$urandom, $urandom};
                end
                dev = 5'($urandom);
                if (board.regions[j].devices != 0 && $urandom_range(0, 1) == 0) begin
                    while (!board.regions[j].devices[dev]) dev = 5'($urandom);
                end
                aflags = 6'($urandom);
                if ($urandom_range(0, 2) == 0) begin
                    put_txn(K_READ_EXCL, addr, dev, aflags);
                end else begin
                    put_txn(t_kind'($urandom_range(0, 7)), addr, dev, aflags);
                end
            end
        end

        drain_results();
        repeat (40) @(posedge i_clk);
        if (board.errors == 0 && board.verdicts.size() == 0) begin
            $display("coherence_access_region_firewall_top_tb: done, clean");
        end else begin
            $display("coherence_access_region_firewall_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/carf_pkg.sv
rtl/core/carf_ram.sv
rtl/core/carf_ctrl.sv
rtl/core/coherence_access_region_firewall_top.sv
tb/coherence_access_region_firewall_top_tb.sv
